@@ src/mrq_pkg.sv @@
`timescale 1ns / 1ps

package mrq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int LEVEL_COUNT = 4;

   localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W      = $clog2(LEVEL_COUNT);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_COUNT = LEVEL_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W     = $clog2(SLOT_COUNT);

   localparam int OP_W      = 2;
   localparam int LEVEL_W   = 2;
   localparam int ID_W      = 6;
   localparam int STATUS_W  = 2;
   localparam int QUANTUM_W = 5;
   localparam int LCOUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PICK    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      id;
      logic [LEVEL_W-1:0]   level;
      logic [QUANTUM_W-1:0] quantum;
      logic [LCOUNT_W-1:0]  count;
      logic                 from_ram;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   function automatic logic [QUANTUM_W-1:0] quantum_of(input logic [3:0] lv);
      logic [QUANTUM_W-1:0] q;
      if (lv == 4'd0) begin
         q = 5'd1;
      end else if (lv < 4'd4) begin
         q = 5'd1 << (lv + 4'd1);
      end else begin
         q = 5'd0;
      end
      return q;
   endfunction

endpackage

@@ src/mrq_if.sv @@
`timescale 1ns / 1ps

interface mrq_req_if;
   import mrq_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [LEVEL_W-1:0] level;
   logic [ID_W-1:0]    proc_id;

   modport source (output valid, output op, output level, output proc_id, input ready);
   modport sink (input valid, input op, input level, input proc_id, output ready);
endinterface

interface mrq_rsp_if;
   import mrq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ID_W-1:0]      out_id;
   logic [LEVEL_W-1:0]   out_level;
   logic [QUANTUM_W-1:0] quantum;
   logic [LCOUNT_W-1:0]  level_count;

   modport source (output valid, output status, output out_id, output out_level,
                   output quantum, output level_count, input ready);
   modport sink (input valid, input status, input out_id, input out_level,
                 input quantum, input level_count, output ready);
endinterface

@@ src/mrq_ram.sv @@
`timescale 1ns / 1ps

module mrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mrq_ctrl.sv @@
`timescale 1ns / 1ps

module mrq_ctrl import mrq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  op_type             op,
   input  logic [LEVEL_W-1:0] level,
   input  logic [ID_W-1:0]    proc_id,
   output result_type         result,
   output ram_wr_type         ram_wr,
   output ram_rd_type         ram_rd
);

   logic [PTR_W-1:0] wp_ff [LEVEL_COUNT];
   logic [PTR_W-1:0] wp_in [LEVEL_COUNT];
   logic [PTR_W-1:0] rp_ff [LEVEL_COUNT];
   logic [PTR_W-1:0] rp_in [LEVEL_COUNT];
   logic [CNT_W-1:0] cnt_ff [LEVEL_COUNT];
   logic [CNT_W-1:0] cnt_in [LEVEL_COUNT];

   logic [LVL_W-1:0] lv_idx;
   logic             exists;
   logic [CNT_W-1:0] cnt_sel;
   logic             found;
   logic [LVL_W-1:0] pick_idx;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] idx,
                                                   input logic [PTR_W-1:0] ptr);
      return ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
   endfunction

   assign lv_idx  = LVL_W'(level);
   assign exists  = (32'(level) < LEVEL_COUNT);
   assign cnt_sel = exists ? cnt_ff[lv_idx] : '0;

   always_comb begin
      found    = 1'b0;
      pick_idx = '0;
      for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            found    = 1'b1;
            pick_idx = LVL_W'(i);
         end
      end
   end

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      result = '{status: ST_OK, id: '0, level: level, quantum: quantum_of(4'(level)),
                 count: LCOUNT_W'(cnt_sel), from_ram: 1'b0};
      ram_wr = '{en: 1'b0, addr: slot_addr(lv_idx, wp_ff[lv_idx]), data: proc_id};
      ram_rd = '{en: 1'b0, addr: slot_addr(lv_idx, rp_ff[lv_idx])};
      unique case (op)
         OP_ENQUEUE: begin
            result.id = proc_id;
            if (!exists || cnt_sel == CNT_W'(QUEUE_DEPTH)) begin
               result.status = ST_FULL;
            end else begin
               result.count    = LCOUNT_W'(cnt_sel + 1'b1);
               ram_wr.en       = accept;
               if (accept) begin
                  wp_in[lv_idx]  = advance(wp_ff[lv_idx]);
                  cnt_in[lv_idx] = cnt_sel + 1'b1;
               end
            end
         end
         OP_DEQUEUE: begin
            if (!exists || cnt_sel == '0) begin
               result.status = ST_EMPTY;
               result.count  = '0;
            end else begin
               result.count    = LCOUNT_W'(cnt_sel - 1'b1);
               result.from_ram = 1'b1;
               ram_rd.en       = accept;
               if (accept) begin
                  rp_in[lv_idx]  = advance(rp_ff[lv_idx]);
                  cnt_in[lv_idx] = cnt_sel - 1'b1;
               end
            end
         end
         OP_PICK: begin
            if (found) begin
               result.level    = LEVEL_W'(pick_idx);
               result.quantum  = quantum_of(4'(pick_idx));
               result.count    = LCOUNT_W'(cnt_ff[pick_idx] - 1'b1);
               result.from_ram = 1'b1;
               ram_rd.en       = accept;
               ram_rd.addr     = slot_addr(pick_idx, rp_ff[pick_idx]);
               if (accept) begin
                  rp_in[pick_idx]  = advance(rp_ff[pick_idx]);
                  cnt_in[pick_idx] = cnt_ff[pick_idx] - 1'b1;
               end
            end else begin
               result.status  = ST_EMPTY;
               result.level   = '0;
               result.quantum = quantum_of(4'd0);
               result.count   = '0;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVEL_COUNT; i++) begin
            wp_ff[i]  <= '0;
            rp_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_write_only_ok: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> (result.status == ST_OK && op == OP_ENQUEUE))
      else $error("slot write without a successful enqueue");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ram_rd.en && op == OP_DEQUEUE) |-> cnt_ff[lv_idx] != '0)
      else $error("slot read from an empty level");

   a_enqueue_count: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |=> cnt_ff[$past(lv_idx)] == CNT_W'($past(cnt_sel) + 1'b1))
      else $error("level count did not grow after enqueue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      exists |-> cnt_sel <= CNT_W'(QUEUE_DEPTH))
      else $error("level count above queue depth");
`endif

endmodule

@@ src/multilevel_ready_queues.sv @@
`timescale 1ns / 1ps
// result: shown in the cycle after its request transaction is accepted
// throughput: one transaction per cycle unless the result stalls; the slot read and the level pointers
//    and counts are handled in the accept cycle, the slot data lands in the result stage
// reset: synchronous, clears all level pointers and counts and the result valid;
//    the slot memory is not cleared and is read only where it was written

module multilevel_ready_queues import mrq_pkg::*; (
   input logic clock,
   input logic reset,
   mrq_req_if.sink   req_ch,
   mrq_rsp_if.source rsp_ch
);

   logic       accept;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result;
   result_type result_ff;
   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   logic [ID_W-1:0] ram_rdata;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   mrq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (op_type'(req_ch.op)),
      .level   (req_ch.level),
      .proc_id (req_ch.proc_id),
      .result  (result),
      .ram_wr  (ram_wr),
      .ram_rd  (ram_rd)
   );

   mrq_ram #(
      .WIDTH (ID_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = result_ff.status;
   assign rsp_ch.out_id      = result_ff.from_ram ? ram_rdata : result_ff.id;
   assign rsp_ch.out_level   = result_ff.level;
   assign rsp_ch.quantum     = result_ff.quantum;
   assign rsp_ch.level_count = result_ff.count;

endmodule

@@ verif/multilevel_ready_queues_tb.sv @@
`timescale 1ns / 1ps

module multilevel_ready_queues_tb;
   import mrq_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 900;
   localparam int HOLD_OFF_AT    = 300;
   localparam int HOLD_OFF_LEN   = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] level;
      logic [ID_W-1:0]    id;
   } sched_req_type;

   typedef struct {
      status_type           status;
      logic [ID_W-1:0]      id;
      logic [LEVEL_W-1:0]   level;
      logic [QUANTUM_W-1:0] quantum;
      logic [LCOUNT_W-1:0]  count;
   } sched_reply_type;

   logic clock;
   logic reset;

   mrq_req_if req_bus ();
   mrq_rsp_if rsp_bus ();

   multilevel_ready_queues u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   sched_req_type   op_backlog[$];
   sched_reply_type awaited_replies[$];

   // shadow of the ready queues
   logic [ID_W-1:0] slot_mem [LEVEL_COUNT][QUEUE_DEPTH];
   int unsigned     head_idx [LEVEL_COUNT];
   int unsigned     tail_idx [LEVEL_COUNT];
   int unsigned     fill     [LEVEL_COUNT];

   int mismatches  = 0;
   int cycle_count = 0;
   int idle_cycles = 0;
   int req_idle    = 0;
   int rsp_idle    = 0;
   int rsp_seen    = 0;
   bit held_off    = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [QUANTUM_W-1:0] level_quantum(input logic [LEVEL_W-1:0] lv);
      if (lv == 0) begin
         return 5'd1;
      end
      return QUANTUM_W'(1) << (lv + 1);
   endfunction

   function automatic logic [ID_W-1:0] pop_level(input int lv);
      logic [ID_W-1:0] id;
      id = slot_mem[lv][head_idx[lv]];
      head_idx[lv] = (head_idx[lv] + 1) % QUEUE_DEPTH;
      fill[lv]--;
      return id;
   endfunction

   function automatic sched_reply_type sched_outcome(input sched_req_type rq);
      sched_reply_type o;
      int lv;
      lv        = rq.level;
      o.status  = ST_OK;
      o.id      = '0;
      o.level   = rq.level;
      o.quantum = level_quantum(rq.level);
      o.count   = LCOUNT_W'(fill[lv]);
      case (rq.op)
         OP_ENQUEUE: begin
            o.id = rq.id;
            if (fill[lv] >= QUEUE_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               slot_mem[lv][tail_idx[lv]] = rq.id;
               tail_idx[lv] = (tail_idx[lv] + 1) % QUEUE_DEPTH;
               fill[lv]++;
               o.count = LCOUNT_W'(fill[lv]);
            end
         end
         OP_DEQUEUE: begin
            if (fill[lv] == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.id    = pop_level(lv);
               o.count = LCOUNT_W'(fill[lv]);
            end
         end
         OP_PICK: begin
            o.status  = ST_EMPTY;
            o.level   = '0;
            o.quantum = level_quantum('0);
            o.count   = '0;
            for (int l = 0; l < LEVEL_COUNT; l++) begin
               if (fill[l] != 0) begin
                  o.status  = ST_OK;
                  o.id      = pop_level(l);
                  o.level   = LEVEL_W'(l);
                  o.quantum = level_quantum(LEVEL_W'(l));
                  o.count   = LCOUNT_W'(fill[l]);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic int pick_gap(input int side);
      int r;
      // windows with no idling at all
      if ((((cycle_count >> 6) + side) % 4) == 0) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return OP_ENQUEUE;
      end else if (r < 70) begin
         return OP_DEQUEUE;
      end else if (r < 95) begin
         return OP_PICK;
      end
      return OP_UNUSED;
   endfunction

   function automatic void add_op(input logic [OP_W-1:0] op, input int lv, input int id);
      sched_req_type rq;
      rq.op    = op;
      rq.level = LEVEL_W'(lv);
      rq.id    = ID_W'(id);
      op_backlog.push_back(rq);
   endfunction

   function automatic void check_field(input string name, input logic [6:0] want,
                                       input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // request driver and predictor
   always @(posedge clock) begin
      sched_req_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_idle = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rq.op    = req_bus.op;
            rq.level = req_bus.level;
            rq.id    = req_bus.proc_id;
            awaited_replies.push_back(sched_outcome(rq));
            req_idle = pick_gap(0);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered transaction
         end else if (req_idle > 0) begin
            req_bus.valid <= 1'b0;
            req_idle--;
         end else if (op_backlog.size() > 0) begin
            rq = op_backlog.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.op      <= rq.op;
            req_bus.level   <= rq.level;
            req_bus.proc_id <= rq.id;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      sched_reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_idle = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected transaction, actual status %0d id %0d level %0d",
                        $time, rsp_bus.status, rsp_bus.out_id, rsp_bus.out_level);
               mismatches++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", 7'(want.status), 7'(rsp_bus.status));
               check_field("out_id", 7'(want.id), 7'(rsp_bus.out_id));
               check_field("out_level", 7'(want.level), 7'(rsp_bus.out_level));
               check_field("quantum", 7'(want.quantum), 7'(rsp_bus.quantum));
               check_field("level_count", want.count, rsp_bus.level_count);
            end
            rsp_seen++;
            rsp_idle = pick_gap(1);
         end
         // one long back-pressure stretch so the block fills up
         if (rsp_seen >= HOLD_OFF_AT && !held_off) begin
            held_off = 1'b1;
            rsp_idle = HOLD_OFF_LEN;
         end
         if (rsp_idle > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_idle--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int lv;
      int kind;
      int n;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = '0;
      req_bus.level   = '0;
      req_bus.proc_id = '0;
      rsp_bus.ready   = 1'b0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         head_idx[l] = 0;
         tail_idx[l] = 0;
         fill[l]     = 0;
      end

      // directed: empty levels, unused op, id extremes, priority order
      add_op(OP_PICK, 0, 0);
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         add_op(OP_DEQUEUE, l, 63);
      end
      add_op(OP_UNUSED, 2, 63);
      add_op(OP_ENQUEUE, 0, 0);
      add_op(OP_ENQUEUE, 3, 63);
      add_op(OP_ENQUEUE, 1, 21);
      add_op(OP_ENQUEUE, 2, 42);
      add_op(OP_ENQUEUE, 3, 5);
      add_op(OP_UNUSED, 3, 0);
      add_op(OP_PICK, 3, 63);
      add_op(OP_PICK, 0, 0);
      add_op(OP_DEQUEUE, 3, 0);
      add_op(OP_PICK, 1, 0);
      add_op(OP_PICK, 2, 0);
      add_op(OP_PICK, 0, 0);
      add_op(OP_DEQUEUE, 3, 0);

      // fill one level past full, then drain half of it
      lv = $urandom_range(0, LEVEL_COUNT - 1);
      repeat (QUEUE_DEPTH + 3) add_op(OP_ENQUEUE, lv, $urandom_range(0, 63));
      repeat (QUEUE_DEPTH / 2) add_op(OP_DEQUEUE, lv, $urandom_range(0, 63));

      while (op_backlog.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         lv   = $urandom_range(0, LEVEL_COUNT - 1);
         if (kind < 5) begin
            repeat (20) add_op(rand_op(), $urandom_range(0, 3), $urandom_range(0, 63));
         end else if (kind < 7) begin
            n = $urandom_range(10, 70);
            repeat (n) add_op(OP_ENQUEUE, lv, $urandom_range(0, 63));
         end else if (kind < 9) begin
            n = $urandom_range(5, 40);
            repeat (n) add_op($urandom_range(0, 1) ? OP_DEQUEUE : OP_PICK, lv,
                              $urandom_range(0, 63));
         end else begin
            repeat (10) add_op(OP_PICK, $urandom_range(0, 3), $urandom_range(0, 63));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_bus.valid || awaited_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/mrq_pkg.sv
src/mrq_if.sv
src/mrq_ram.sv
src/mrq_ctrl.sv
src/multilevel_ready_queues.sv
verif/multilevel_ready_queues_tb.sv
